[rtl/mpr_pkg.sv]
// ---------------------------------------------------------------------------
// mpr_pkg: shared types and helpers for the multidrop packet receiver
// Holds the transaction structs, framing constants and the byte-wise
// CRC-16/CCITT-FALSE update used by the receiver.
// ---------------------------------------------------------------------------
package mpr_pkg;

  localparam logic [15:0] CRC_INIT       = 16'hFFFF;
  localparam logic [9:0]  FRAME_OVERHEAD = 10'd4;
  localparam logic [9:0]  CRC_BYTES      = 10'd2;

  // One received nine-bit serial word.
  typedef struct packed {
    logic       address_flag;
    logic [7:0] data_byte;
  } word_t;

  // One result transaction.
  typedef struct packed {
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic       packet_end;
    logic       packet_good;
    logic [7:0] data_length;
  } result_t;

  // Byte-wise CRC-16 update, polynomial 0x1021, MSB first.
  function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
    logic [7:0] x;
    begin
      x = crc[15:8] ^ b;
      x = x ^ {4'd0, x[7:4]};
      crc_add = {crc[7:0], 8'd0} ^ {x[3:0], 12'd0} ^ {3'd0, x, 5'd0} ^ {8'd0, x};
    end
  endfunction

endpackage

[rtl/mpr_in_stage.sv]
// ---------------------------------------------------------------------------
// mpr_in_stage: input register
// Captures one serial word per transaction and holds it until the decode
// stage consumes it.
// ---------------------------------------------------------------------------
module mpr_in_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  mpr_pkg::word_t in_word,
  input  logic           advance,
  output logic           word_valid,
  output mpr_pkg::word_t word
);
  import mpr_pkg::*;

  logic accept;
  logic word_valid_next;

  // The register frees up in the same cycle the decode stage takes it.
  assign in_stall = word_valid && !advance;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    word_valid_next = word_valid;
    if (accept) begin
      word_valid_next = 1'b1;
    end else if (advance) begin
      word_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else begin
      word_valid <= word_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      word <= in_word;
    end
  end

endmodule

[rtl/mpr_decoder.sv]
// ---------------------------------------------------------------------------
// mpr_decoder: packet framing and CRC state
// Tracks the packet framing, runs the CRC over address, length and payload,
// and forms the result for the registered word. State moves on advance.
// ---------------------------------------------------------------------------
module mpr_decoder (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [7:0]       cfg_data,
  input  mpr_pkg::word_t   word,
  input  logic             advance,
  output mpr_pkg::result_t result
);
  import mpr_pkg::*;

  logic [7:0]  node_address;
  logic        receiving;
  logic        length_pending;
  logic [8:0]  byte_count;
  logic [8:0]  packet_total;
  logic [15:0] running_crc;
  logic [7:0]  crc_high_received;
  logic [7:0]  length_field;

  logic        receiving_next;
  logic        length_pending_next;
  logic [8:0]  byte_count_next;
  logic [8:0]  packet_total_next;
  logic [15:0] running_crc_next;
  logic [7:0]  crc_high_received_next;
  logic [7:0]  length_field_next;

  logic        hit;
  logic [9:0]  count_plus;
  logic [15:0] crc_in;
  logic [15:0] crc_upd;

  assign hit        = word.address_flag && (word.data_byte == node_address);
  assign count_plus = {1'b0, byte_count} + CRC_BYTES;
  assign crc_in     = hit ? CRC_INIT : running_crc;
  assign crc_upd    = crc_add(crc_in, word.data_byte);

  always_comb begin
    receiving_next         = receiving;
    length_pending_next    = length_pending;
    byte_count_next        = byte_count;
    packet_total_next      = packet_total;
    running_crc_next       = running_crc;
    crc_high_received_next = crc_high_received;
    length_field_next      = length_field;
    result                 = '0;
    if (hit) begin
      // Our address restarts framing, even inside a packet.
      receiving_next      = 1'b1;
      length_pending_next = 1'b1;
      byte_count_next     = 9'd1;
      running_crc_next    = crc_upd;
    end else if (receiving) begin
      if (length_pending) begin
        length_field_next   = word.data_byte;
        packet_total_next   = 9'(({2'd0, word.data_byte}) + FRAME_OVERHEAD);
        length_pending_next = 1'b0;
        running_crc_next    = crc_upd;
      end else if (count_plus < {1'b0, packet_total}) begin
        result.payload_valid = 1'b1;
        result.payload_byte  = word.data_byte;
        result.payload_index = 8'(byte_count - 9'd2);
        running_crc_next     = crc_upd;
      end else if (count_plus == {1'b0, packet_total}) begin
        crc_high_received_next = word.data_byte;
      end else begin
        result.packet_end = 1'b1;
        result.packet_good = (running_crc == {crc_high_received, word.data_byte});
        receiving_next    = 1'b0;
      end
      byte_count_next = byte_count + 9'd1;
    end
    result.data_length = length_field_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_address      <= '0;
      receiving         <= 1'b0;
      length_pending    <= 1'b0;
      byte_count        <= '0;
      packet_total      <= '0;
      running_crc       <= CRC_INIT;
      crc_high_received <= '0;
      length_field      <= '0;
    end else begin
      if (cfg_write) begin
        node_address <= cfg_data;
      end
      if (advance) begin
        receiving         <= receiving_next;
        length_pending    <= length_pending_next;
        byte_count        <= byte_count_next;
        packet_total      <= packet_total_next;
        running_crc       <= running_crc_next;
        crc_high_received <= crc_high_received_next;
        length_field      <= length_field_next;
      end
    end
  end

endmodule

[rtl/mpr_out_stage.sv]
// ---------------------------------------------------------------------------
// mpr_out_stage: result register
// Holds one result transaction until the downstream side takes it.
// ---------------------------------------------------------------------------
module mpr_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             word_valid,
  input  mpr_pkg::result_t result,
  output logic             advance,
  output logic             out_valid,
  input  logic             out_stall,
  output mpr_pkg::result_t out_result
);
  import mpr_pkg::*;

  logic out_valid_next;

  // Load when the register is empty or its content leaves this cycle.
  assign advance = word_valid && (!out_valid || !out_stall);

  always_comb begin
    out_valid_next = out_valid && out_stall;
    if (advance) begin
      out_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= result;
    end
  end

endmodule

[rtl/multidrop_packet_receiver_crc16_top.sv]
// ---------------------------------------------------------------------------
// multidrop_packet_receiver_crc16_top: nine-bit multidrop packet receiver
// Frames address/length/payload/CRC packets and checks CRC-16/CCITT-FALSE.
// ---------------------------------------------------------------------------
// The receiver takes one nine-bit serial word per input transaction and
// returns exactly one result transaction for it, through an input register
// and the result register. While the output is not stalled, a new word can
// be accepted in every clock cycle: the framing and byte-wide CRC update run
// combinationally between the input register and the result register, so
// the sustained rate is one word per cycle. A word whose ninth bit is set
// and whose low byte equals node_address starts a packet, even in
// the middle of another one; the next byte is the length, then the payload
// bytes (each reported with its index), then the CRC high and low bytes. The
// last CRC byte raises packet_end, with packet_good set when the CRC over
// address, length and payload matches. Write node_address only while no
// transaction is in flight; the write port is always ready.
// ---------------------------------------------------------------------------
module multidrop_packet_receiver_crc16_top (
  input  logic       clk,
  input  logic       rst,
  // Configuration write channel.
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] node_address,
  // Input channel.
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       address_flag,
  input  logic [7:0] data_byte,
  // Output channel.
  output logic       out_valid,
  input  logic       out_stall,
  output logic       payload_valid,
  output logic [7:0] payload_byte,
  output logic [7:0] payload_index,
  output logic       packet_end,
  output logic       packet_good,
  output logic [7:0] data_length
);
  import mpr_pkg::*;

  word_t   in_word;
  word_t   word;
  logic    word_valid;
  logic    advance;
  result_t result;
  result_t out_result;

  // The address register takes a write in any cycle.
  assign cfg_ready = 1'b1;

  assign in_word.address_flag = address_flag;
  assign in_word.data_byte    = data_byte;

  mpr_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (in_word),
    .advance    (advance),
    .word_valid (word_valid),
    .word       (word)
  );

  // Framing state advances only when the result register takes the result,
  // so a stalled output never loses or repeats a word.
  mpr_decoder u_decoder (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_data  (node_address),
    .word      (word),
    .advance   (advance),
    .result    (result)
  );

  mpr_out_stage u_out_stage (
    .clk        (clk),
    .rst        (rst),
    .word_valid (word_valid),
    .result     (result),
    .advance    (advance),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_result (out_result)
  );

  assign payload_valid = out_result.payload_valid;
  assign payload_byte  = out_result.payload_byte;
  assign payload_index = out_result.payload_index;
  assign packet_end    = out_result.packet_end;
  assign packet_good   = out_result.packet_good;
  assign data_length   = out_result.data_length;

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: self-checking bench for the nine-bit multidrop packet receiver
// Streams framed packets, broken packets and line noise into the receiver,
// predicts every result transaction and compares it field by field.
// ---------------------------------------------------------------------------
module tb;
  import mpr_pkg::*;

  localparam int          RESET_CYCLES = 7;
  localparam logic [15:0] CRC_POLY     = 16'h1021;
  localparam int          LONG_HOLD    = 60;
  localparam int          STUCK_LIMIT  = 500;
  localparam int          PHASE_WORDS  = 110;
  localparam int          PHASE_COUNT  = 5;
  localparam int          MAX_REPORTS  = 100;

  // Every input of the receiver has a known value from time zero.
  logic       clk          = 1'b0;
  logic       rst          = 1'b1;
  logic       cfg_valid    = 1'b0;
  logic       cfg_ready;
  logic [7:0] node_address = 8'h00;
  logic       in_valid     = 1'b0;
  logic       in_stall;
  logic       address_flag = 1'b0;
  logic [7:0] data_byte    = 8'h00;
  logic       out_valid;
  logic       out_stall    = 1'b0;
  logic       payload_valid;
  logic [7:0] payload_byte;
  logic [7:0] payload_index;
  logic       packet_end;
  logic       packet_good;
  logic [7:0] data_length;

  multidrop_packet_receiver_crc16_top dut (.*);

  // 4 ns clock: two delays, high then low.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Words waiting to be sent and the results they are expected to produce.
  word_t   pending_words[$];
  result_t expected_results[$];

  // Idling controls. An odds value of N gives a 1-in-N chance per cycle of
  // starting a burst; zero turns idling off on that side.
  int gap_left    = 0;
  int gap_odds    = 0;
  int stall_left  = 0;
  int stall_odds  = 0;
  int flag_odds   = 8;
  bit hold_request = 1'b0;

  bit word_accepted = 1'b0;
  int fail_count    = 0;
  int stuck_cycles  = 0;

  // Shadow of the receiver's framing state, advanced once per accepted word.
  logic [7:0]  own_address = 8'h00;
  logic        in_packet   = 1'b0;
  logic        want_length = 1'b0;
  logic [9:0]  bytes_seen  = 10'd0;
  logic [9:0]  frame_size  = 10'd0;
  logic [15:0] crc_acc     = CRC_INIT;
  logic [7:0]  crc_hi      = 8'h00;
  logic [7:0]  len_held    = 8'h00;

  // Bit-serial CRC-16/CCITT-FALSE step over one byte, MSB first.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  // Works out the result for one word and moves the shadow state along.
  // The address word of this node always restarts framing, even mid-packet;
  // any other word inside a packet is taken as a byte, flag or not.
  task predict_word(input word_t w, output result_t r);
    r = '0;
    if (w.address_flag && w.data_byte == own_address) begin
      in_packet   = 1'b1;
      want_length = 1'b1;
      bytes_seen  = 10'd1;
      crc_acc     = crc16_byte(CRC_INIT, w.data_byte);
    end else if (in_packet) begin
      if (want_length) begin
        len_held    = w.data_byte;
        frame_size  = {2'b00, w.data_byte} + FRAME_OVERHEAD;
        want_length = 1'b0;
        crc_acc     = crc16_byte(crc_acc, w.data_byte);
      end else if (bytes_seen + 10'd2 < frame_size) begin
        r.payload_valid = 1'b1;
        r.payload_byte  = w.data_byte;
        r.payload_index = 8'(bytes_seen - 10'd2);
        crc_acc         = crc16_byte(crc_acc, w.data_byte);
      end else if (bytes_seen + 10'd2 == frame_size) begin
        crc_hi = w.data_byte;
      end else begin
        r.packet_end  = 1'b1;
        r.packet_good = (crc_acc == {crc_hi, w.data_byte});
        in_packet     = 1'b0;
      end
      bytes_seen = bytes_seen + 10'd1;
    end
    r.data_length = len_held;
  endtask

  // Reports are capped so that a badly broken build does not flood the log.
  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $error("%s", msg);
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      note_failure($sformatf("%s: expected 0x%0h, actual 0x%0h", name, want, got));
    end
  endfunction

  // Monitor: samples both channels at the rising edge, before the receiver's
  // registers update. Accepted words are predicted at once; accepted results
  // are checked against the oldest prediction.
  always @(posedge clk) begin : monitor
    result_t want;
    result_t got;
    word_accepted = in_valid && !in_stall;
    if (!rst && (word_accepted || (out_valid && !out_stall) || (cfg_valid && cfg_ready))) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
    end
    if (!rst && word_accepted) begin
      predict_word(word_t'({address_flag, data_byte}), want);
      expected_results.push_back(want);
    end
    if (!rst && out_valid && !out_stall) begin
      got = {payload_valid, payload_byte, payload_index, packet_end, packet_good, data_length};
      if (expected_results.size() == 0) begin
        note_failure("result transaction arrived with nothing expected");
      end else begin
        want = expected_results.pop_front();
        check_field("payload_valid", want.payload_valid, got.payload_valid);
        check_field("payload_byte", want.payload_byte, got.payload_byte);
        check_field("payload_index", want.payload_index, got.payload_index);
        check_field("packet_end", want.packet_end, got.packet_end);
        check_field("packet_good", want.packet_good, got.packet_good);
        check_field("data_length", want.data_length, got.data_length);
      end
    end
  end

  // Driver: moves on only once the word on the bus has been taken, so a
  // stalled transaction keeps its payload. Gaps are only started between
  // transactions.
  always @(negedge clk) begin : driver
    word_t w;
    if (!in_valid || word_accepted) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
        gap_left = $urandom_range(0, 10);
        in_valid <= 1'b0;
      end else if (pending_words.size() != 0) begin
        w = pending_words.pop_front();
        in_valid     <= 1'b1;
        address_flag <= w.address_flag;
        data_byte    <= w.data_byte;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver side stalls. A hold request turns into one long stall that
  // lets the pipeline fill and push back on the input.
  always @(negedge clk) begin : receiver
    if (hold_request) begin
      stall_left   = LONG_HOLD;
      hold_request = 1'b0;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
      stall_left = $urandom_range(0, 10);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog: too long without any transaction on any channel.
  initial begin : watchdog
    wait (stuck_cycles >= STUCK_LIMIT);
    $display("status: fail");
    $finish;
  end

  task automatic queue_word(input logic flag, input logic [7:0] b);
    pending_words.push_back(word_t'({flag, b}));
  endtask

  // A byte inside a packet may go out with the ninth bit set, which makes it
  // look like an address word for some other node; never for this node.
  function automatic word_t data_word(input logic [7:0] b);
    logic flag;
    flag = (b != own_address) && ($urandom_range(1, flag_odds) == 1);
    return word_t'({flag, b});
  endfunction

  // Builds one packet for the current node address with random payload.
  // keep < 0 sends the whole frame; otherwise only its first keep words.
  task automatic queue_packet(input logic [7:0] len, input bit bad_crc, input int keep,
                              inout int made);
    word_t       frame[$];
    logic [15:0] crc;
    logic [7:0]  b;
    frame.push_back(word_t'({1'b1, own_address}));
    crc = crc16_byte(CRC_INIT, own_address);
    frame.push_back(data_word(len));
    crc = crc16_byte(crc, len);
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom);
      frame.push_back(data_word(b));
      crc = crc16_byte(crc, b);
    end
    if (bad_crc) crc = crc ^ 16'($urandom_range(1, 16'hFFFF));
    frame.push_back(data_word(crc[15:8]));
    frame.push_back(data_word(crc[7:0]));
    if (keep < 0 || keep > frame.size()) keep = frame.size();
    for (int i = 0; i < keep; i++) pending_words.push_back(frame[i]);
    made += keep;
  endtask

  // Mostly well-formed packets of small length, now and then a longer one,
  // some with a bad CRC, some cut short, plus bits of line noise.
  task automatic random_traffic(input int target);
    int made;
    int pick;
    int len;
    made = 0;
    while (made < target) begin
      pick = $urandom_range(0, 9);
      len  = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 64) : $urandom_range(0, 12);
      if (pick == 0) begin
        repeat ($urandom_range(1, 3)) queue_word(1'($urandom), 8'($urandom));
      end else if (pick == 1) begin
        queue_packet(8'(len), 1'b0, $urandom_range(1, len + 3), made);
      end else begin
        queue_packet(8'(len), $urandom_range(0, 3) == 0, -1, made);
      end
    end
  endtask

  // Waits until every queued word has been sent and every result checked.
  // The check runs at the rising edge, where the driver's updates have
  // settled, and the task returns on the following falling edge.
  task automatic drain();
    do @(posedge clk);
    while (pending_words.size() != 0 || in_valid || expected_results.size() != 0);
    @(negedge clk);
  endtask

  // Register write, done only while the receiver is idle.
  task automatic set_node_address(input logic [7:0] value);
    cfg_valid    <= 1'b1;
    node_address <= value;
    do @(posedge clk);
    while (!cfg_ready);
    own_address = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    int         made;
    logic [7:0] next_address;
    made = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part, with the node address still at its reset value of zero.
    gap_odds   = 4;
    stall_odds = 4;
    // Idle words are ignored, including an address word for another node.
    queue_word(1'b0, 8'h00);
    queue_word(1'b0, 8'hFF);
    queue_word(1'b1, 8'hFF);
    // Zero-length packet: the CRC high byte follows the length directly.
    queue_packet(8'd0, 1'b0, -1, made);
    // Every nonzero byte carries the ninth bit, so foreign address words sit
    // inside the packet; the CRC is also corrupted.
    flag_odds = 1;
    queue_packet(8'd2, 1'b1, -1, made);
    flag_odds = 8;
    // Restart: this node's address arrives in the middle of a payload.
    queue_packet(8'd3, 1'b0, 3, made);
    queue_packet(8'd1, 1'b0, -1, made);
    drain();

    // Random phases, each under its own node address and idling mix.
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase)
        0: begin
          next_address = 8'hFF;
        end
        2: begin
          next_address = 8'h00;
        end
        default: begin
          next_address = 8'($urandom);
        end
      endcase
      set_node_address(next_address);
      gap_odds   = $urandom_range(2, 8);
      stall_odds = (phase == 3) ? 0 : $urandom_range(2, 8);
      if (phase == 0) begin
        // Longest packet: indexes run up to their maximum.
        queue_packet(8'd255, 1'b0, -1, made);
      end
      if (phase == 1) begin
        // Sender runs flat out while the receiver holds off for a while.
        gap_odds     = 0;
        hold_request = 1'b1;
      end
      if (phase == PHASE_COUNT - 1) begin
        // Final stretch at full rate on both sides.
        gap_odds   = 0;
        stall_odds = 0;
      end
      random_traffic(PHASE_WORDS);
      drain();
    end

    // A few more cycles to catch any stray result.
    repeat (8) @(posedge clk);
    if (expected_results.size() != 0) note_failure("results still outstanding at end of run");
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[multidrop_packet_receiver_crc16_top.f]
rtl/mpr_pkg.sv
rtl/mpr_in_stage.sv
rtl/mpr_decoder.sv
rtl/mpr_out_stage.sv
rtl/multidrop_packet_receiver_crc16_top.sv
sim/tb.sv
